// File: rtl/flp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package flp_pkg;

	localparam int DEF_RING_DEPTH  = 32;
	localparam int DEF_MAX_PAYLOAD = 10;
	localparam int MAX_RESULTS     = 32;

	localparam logic [7:0] FLAG_ONE = 8'hA1;
	localparam logic [7:0] FLAG_TWO = 8'hA2;
	localparam logic [7:0] MIN_SIZE = 8'd6;
	localparam int         OVERHEAD = 5;

	localparam int CFG_DATA_W = 4;

	// register indexes on the configuration port
	localparam logic CFG_BLOCK_WHEN_FULL = 1'b0;
	localparam logic CFG_MAX_FRAME_LEN   = 1'b1;

	localparam logic       RST_BLOCK_WHEN_FULL = 1'b1;
	localparam logic [3:0] RST_MAX_FRAME_LEN   = 4'd15;

	typedef enum logic [2:0] {
		PH_WAIT_A1,
		PH_WAIT_A2,
		PH_SIZE,
		PH_DATA,
		PH_END_A2,
		PH_END_A1,
		PH_ERROR
	} phase_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_POP,
		S_SCAN_RD,
		S_SCAN_EX,
		S_EMIT
	} state_t;

	typedef struct packed {
		logic push;
		logic start;
		logic pop;
		logic scan_rd;
		logic scan_step;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic cont;
		logic frame_done;
		logic err_phase;
		logic scan_found;
		logic scan_end;
		logic out_free;
		logic emit_last;
	} status_t;

endpackage

`default_nettype wire

// File: rtl/flp_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module flp_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	input  wire logic             func,
	output logic                  in_stall,
	input  wire flp_pkg::status_t st,
	output flp_pkg::cmd_t         cmd
);
	import flp_pkg::*;

	state_t state_q;
	state_t state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid && func) state_nx = S_CHECK;
			end
			S_CHECK: begin
				state_nx = st.cont ? S_POP : S_IDLE;
			end
			S_POP: begin
				if (st.frame_done) state_nx = S_EMIT;
				else if (st.err_phase) state_nx = S_SCAN_RD;
				else state_nx = S_CHECK;
			end
			S_SCAN_RD: begin
				state_nx = S_SCAN_EX;
			end
			S_SCAN_EX: begin
				if (st.scan_found || st.scan_end) state_nx = S_CHECK;
				else state_nx = S_SCAN_RD;
			end
			S_EMIT: begin
				if (st.out_free && st.emit_last) state_nx = S_CHECK;
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	always_comb begin
		in_stall      = (state_q != S_IDLE);
		cmd           = '0;
		cmd.push      = (state_q == S_IDLE) && in_valid && !func;
		cmd.start     = (state_q == S_IDLE) && in_valid && func;
		cmd.pop       = (state_q == S_POP);
		cmd.scan_rd   = (state_q == S_SCAN_RD);
		cmd.scan_step = (state_q == S_SCAN_EX);
		cmd.load_out  = (state_q == S_EMIT) && st.out_free;
	end

endmodule

`default_nettype wire

// File: rtl/flp_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module flp_datapath #(
	parameter int RING_DEPTH  = flp_pkg::DEF_RING_DEPTH,
	parameter int MAX_PAYLOAD = flp_pkg::DEF_MAX_PAYLOAD
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic                        cfg_index,
	input  wire logic [flp_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic [7:0]                  data_byte,
	input  wire flp_pkg::cmd_t               cmd,
	output flp_pkg::status_t                 st,
	input  wire logic                        out_stall,
	output logic                             out_valid,
	output logic [7:0]                       msg_byte,
	output logic [3:0]                       byte_index,
	output logic [3:0]                       msg_length,
	output logic                             last
);
	import flp_pkg::*;

	localparam int PW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam int CW = $clog2(MAX_PAYLOAD + 1);
	localparam int IW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
	localparam int RW = $clog2(2 * RING_DEPTH + 1);
	localparam int NW = $clog2(MAX_RESULTS + MAX_PAYLOAD + 1);

	localparam logic [PW-1:0] PTR_LAST  = PW'(RING_DEPTH - 1);
	localparam logic [RW-1:0] READ_CAP  = RW'(2 * RING_DEPTH);
	localparam logic [NW-1:0] SLOT_NEED = NW'(MAX_PAYLOAD);
	localparam logic [NW-1:0] SLOT_MAX  = NW'(MAX_RESULTS);
	localparam logic [7:0]    SIZE_CAP  = 8'(MAX_PAYLOAD + OVERHEAD);
	localparam logic [CW-1:0] PAY_MAX   = CW'(MAX_PAYLOAD);

	function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
		return (p == PTR_LAST) ? '0 : p + PW'(1);
	endfunction

	logic            bwf_q;
	logic [3:0]      maxlen_q;
	logic [7:0]      ring_mem [RING_DEPTH];
	logic [7:0]      rd_data_q;
	logic [PW-1:0]   rd_addr;
	logic [PW-1:0]   wp_q, rp_q, resync_q, scan_idx_q;
	logic [PW-1:0]   rp_inc, idx_inc;
	logic            empty_q, ovf_q;
	phase_t          phase_q, phase_nx;
	logic [3:0]      fsize_q;
	logic [CW-1:0]   pcnt_q, pcnt_inc;
	logic [7:0]      pstore [MAX_PAYLOAD];
	logic [RW-1:0]   reads_q;
	logic [NW-1:0]   nres_q;
	logic [CW-1:0]   emit_k_q, emit_k_inc;
	logic            out_valid_q;
	logic [7:0]      out_byte_q;
	logic [3:0]      out_index_q, out_len_q;
	logic            out_last_q;

	logic            ovf_nx, push_ok;
	logic            size_ok, data_end;
	logic            resync_take, size_load, data_store, frame_done, err_phase;
	logic [7:0]      b;

	assign b          = rd_data_q;
	assign rp_inc     = ptr_inc(rp_q);
	assign idx_inc    = ptr_inc(scan_idx_q);
	assign pcnt_inc   = pcnt_q + CW'(1);
	assign emit_k_inc = emit_k_q + CW'(1);
	assign rd_addr    = cmd.scan_rd ? scan_idx_q : rp_q;

	// overflow is sticky; once seen, every write is dropped while blocking is set
	assign ovf_nx  = ovf_q | ((rp_q == wp_q) && !empty_q);
	assign push_ok = !(bwf_q && ovf_nx);

	assign size_ok  = (b >= MIN_SIZE) && (b <= {4'b0, maxlen_q}) && (b <= SIZE_CAP);
	assign data_end = (8'(pcnt_inc) + 8'(OVERHEAD)) >= {4'b0, fsize_q};

	always_comb begin
		phase_nx    = phase_q;
		resync_take = 1'b0;
		size_load   = 1'b0;
		data_store  = 1'b0;
		frame_done  = 1'b0;
		err_phase   = 1'b0;
		unique case (phase_q)
			PH_WAIT_A1: begin
				if (b == FLAG_ONE) phase_nx = PH_WAIT_A2;
			end
			PH_WAIT_A2: begin
				if (b == FLAG_TWO) begin
					phase_nx    = PH_SIZE;
					resync_take = 1'b1;
				end else begin
					phase_nx = PH_ERROR;
				end
			end
			PH_SIZE: begin
				size_load = 1'b1;
				phase_nx  = size_ok ? PH_DATA : PH_ERROR;
			end
			PH_DATA: begin
				data_store = 1'b1;
				if (data_end) phase_nx = PH_END_A2;
			end
			PH_END_A2: begin
				phase_nx = (b == FLAG_TWO) ? PH_END_A1 : PH_ERROR;
			end
			PH_END_A1: begin
				if (b == FLAG_ONE) begin
					phase_nx    = PH_WAIT_A1;
					resync_take = 1'b1;
					frame_done  = 1'b1;
				end else begin
					phase_nx = PH_ERROR;
				end
			end
			default: begin
				// byte read in error phase is dropped, then the ring is scanned
				err_phase = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bwf_q    <= RST_BLOCK_WHEN_FULL;
			maxlen_q <= RST_MAX_FRAME_LEN;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_BLOCK_WHEN_FULL: bwf_q    <= cfg_data[0];
				CFG_MAX_FRAME_LEN:   maxlen_q <= cfg_data[3:0];
				default:             ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push && push_ok) ring_mem[wp_q] <= data_byte;
		rd_data_q <= ring_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q     <= '0;
			rp_q     <= '0;
			empty_q  <= 1'b1;
			ovf_q    <= 1'b0;
			phase_q  <= PH_WAIT_A1;
			fsize_q  <= '0;
			pcnt_q   <= '0;
			resync_q <= '0;
			reads_q  <= '0;
			nres_q   <= '0;
		end else begin
			if (cmd.push) begin
				ovf_q <= ovf_nx;
				if (push_ok) begin
					wp_q    <= ptr_inc(wp_q);
					empty_q <= 1'b0;
				end
			end
			if (cmd.start) begin
				reads_q <= '0;
				nres_q  <= '0;
			end
			if (cmd.pop) begin
				rp_q    <= rp_inc;
				empty_q <= (wp_q == rp_inc);
				reads_q <= reads_q + RW'(1);
				phase_q <= phase_nx;
				if (resync_take) resync_q <= rp_inc;
				if (size_load) begin
					fsize_q <= b[3:0];
					pcnt_q  <= '0;
				end
				if (data_store) pcnt_q <= pcnt_inc;
			end
			if (cmd.scan_step) begin
				if (b == FLAG_ONE) begin
					phase_q  <= PH_WAIT_A2;
					resync_q <= idx_inc;
					rp_q     <= idx_inc;
				end else if (idx_inc == wp_q) begin
					phase_q <= PH_WAIT_A1;
				end
			end
			if (cmd.load_out) nres_q <= nres_q + NW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pop && data_store && (pcnt_q < PAY_MAX)) pstore[pcnt_q[IW-1:0]] <= b;
		if (cmd.pop && err_phase) scan_idx_q <= resync_q;
		if (cmd.scan_step) scan_idx_q <= idx_inc;
		if (cmd.pop && frame_done) emit_k_q <= '0;
		if (cmd.load_out) begin
			out_byte_q  <= pstore[emit_k_q[IW-1:0]];
			out_index_q <= 4'(emit_k_q);
			out_len_q   <= 4'(pcnt_q);
			out_last_q  <= (emit_k_inc == pcnt_q);
			emit_k_q    <= emit_k_inc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		st            = '0;
		st.cont       = !empty_q && (reads_q < READ_CAP) && ((nres_q + SLOT_NEED) <= SLOT_MAX);
		st.frame_done = frame_done;
		st.err_phase  = err_phase;
		st.scan_found = (b == FLAG_ONE);
		st.scan_end   = (idx_inc == wp_q);
		st.out_free   = !out_valid_q || !out_stall;
		st.emit_last  = (emit_k_inc == pcnt_q);
	end

	assign out_valid  = out_valid_q;
	assign msg_byte   = out_byte_q;
	assign byte_index = out_index_q;
	assign msg_length = out_len_q;
	assign last       = out_last_q;

endmodule

`default_nettype wire

// File: rtl/flagged_length_frame_parser.sv
// Receive ring and frame parser. A write item (func 0) stores one byte in the
// ring unless an overflow was seen while blocking is set. A process item
// (func 1) drains the ring through the parser (A1 A2, size byte, payload,
// A2 A1) and emits each good frame as one output item per payload byte.
// Because the ring has one registered read port, every byte read passes
// through the CHECK and POP states, each entry walked by a resync scan
// through SCAN_RD and SCAN_EX, and each payload byte is emitted from EMIT
// while the output is not stalled; a drain reads at most 2*RING_DEPTH bytes
// and each resync scan walks up to RING_DEPTH entries. Input is stalled while
// a process item runs; the output register lets the next item in while the
// last result waits. Configuration writes must come only while idle (the block
// does not enforce it); reading an unwritten ring entry gives an undefined byte.
`timescale 1ns / 1ps
`default_nettype none

module flagged_length_frame_parser #(
	parameter int RING_DEPTH  = flp_pkg::DEF_RING_DEPTH,
	parameter int MAX_PAYLOAD = flp_pkg::DEF_MAX_PAYLOAD
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic                            cfg_index,
	input  wire logic [flp_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic                            func,
	input  wire logic [7:0]                      data_byte,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic [7:0]                           msg_byte,
	output logic [3:0]                           byte_index,
	output logic [3:0]                           msg_length,
	output logic                                 last
);
	import flp_pkg::*;

	cmd_t    cmd;
	status_t st;

	flp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.func     (func),
		.in_stall (in_stall),
		.st       (st),
		.cmd      (cmd)
	);

	flp_datapath #(
		.RING_DEPTH  (RING_DEPTH),
		.MAX_PAYLOAD (MAX_PAYLOAD)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.data_byte  (data_byte),
		.cmd        (cmd),
		.st         (st),
		.out_stall  (out_stall),
		.out_valid  (out_valid),
		.msg_byte   (msg_byte),
		.byte_index (byte_index),
		.msg_length (msg_length),
		.last       (last)
	);

endmodule

`default_nettype wire
